[sv/drq_pkg.sv]
// Shared types, codes and constants for the drop-oldest ring queue.
// No dependencies; used by drq_ctrl, drq_store and drop_oldest_ring_queue.
package drq_pkg;

    // Compile-time default for the largest ring the storage can hold
    localparam int unsigned MAX_DEPTH_DEF = 1024;

    // Fixed field widths
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned CNT_OUT_W = 11;
    localparam int unsigned STAT_W  = 64;

    // Ring depth after reset
    localparam logic [CFG_W-1:0] RING_DEPTH_RST = 11'd1024;

    // Operation codes carried in tuser
    localparam logic [1:0] OP_PUBLISH = 2'd0;
    localparam logic [1:0] OP_CONSUME = 2'd1;
    localparam logic [1:0] OP_CLOSE   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    // One stored entry
    typedef struct packed {
        logic [63:0] seq;
        logic [31:0] bytes;
        logic [31:0] handle;
        logic [63:0] slot;
    } t_entry;

    // Clamp a programmed depth into [2, max_d]
    function automatic int unsigned eff_depth(logic [CFG_W-1:0] d, int unsigned max_d);
        int unsigned v;
        v = int'(d);
        if (v < 2) begin
            v = 2;
        end else if (v > max_d) begin
            v = max_d;
        end
        return v;
    endfunction

endpackage

[sv/drq_store.sv]
// Entry storage for the drop-oldest ring queue: one write port, one
// registered read port. Depends on drq_pkg (t_entry).
module drq_store #(
    parameter int unsigned MAX_DEPTH = drq_pkg::MAX_DEPTH_DEF,
    localparam int unsigned AW = $clog2(MAX_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  drq_pkg::t_entry  i_wentry,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output drq_pkg::t_entry  o_rentry
);

    drq_pkg::t_entry r_mem [MAX_DEPTH];
    drq_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wentry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rentry = r_rd;

endmodule

[sv/drq_ctrl.sv]
// Pointer, count, statistics and per-transaction result logic for the
// drop-oldest ring queue. Depends on drq_pkg (codes, t_entry, eff_depth).
module drq_ctrl #(
    parameter int unsigned MAX_DEPTH = drq_pkg::MAX_DEPTH_DEF,
    localparam int unsigned AW = $clog2(MAX_DEPTH),
    localparam int unsigned CW = $clog2(MAX_DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [drq_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_accept,
    input  logic [1:0]                 i_op,
    input  logic [63:0]                i_slot,
    input  logic [31:0]                i_handle,
    input  logic [31:0]                i_bytes,
    // storage side
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output drq_pkg::t_entry            o_wentry,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    // result of the last transaction
    output logic [1:0]                 o_status,
    output logic [63:0]                o_seq,
    output logic                       o_dropped,
    output logic                       o_rd_ok,
    output logic [CW-1:0]              o_count,
    output logic [CW-1:0]              o_peak,
    output logic [63:0]                o_drop_total,
    output logic [63:0]                o_pub_total,
    output logic [63:0]                o_cons_total,
    output logic [63:0]                o_byte_total
);

    logic [CW-1:0] r_depth;
    logic [AW-1:0] r_wr_idx, r_rd_idx;
    logic [CW-1:0] r_count, r_peak;
    logic [63:0]   r_next_seq;
    logic          r_closed;
    logic [63:0]   r_drop_ctr, r_pub_ctr, r_cons_ctr, r_byte_ctr;
    logic [1:0]    r_status;
    logic [63:0]   r_seq;
    logic          r_dropped, r_rd_ok;

    logic [AW-1:0] n_wr_idx, n_rd_idx;
    logic [CW-1:0] n_count, n_peak;
    logic [63:0]   n_next_seq;
    logic          n_closed;
    logic [63:0]   n_drop_ctr, n_pub_ctr, n_cons_ctr, n_byte_ctr;
    logic [1:0]    n_status;
    logic [63:0]   n_seq;
    logic          n_dropped, n_rd_ok;
    logic          w_pub, w_cons;

    logic [CW-1:0] w_wr_inc, w_rd_inc;
    logic [AW-1:0] w_wr_adv, w_rd_adv;

    // index + 1, wrapping at the active depth
    assign w_wr_inc = CW'(r_wr_idx) + CW'(1);
    assign w_rd_inc = CW'(r_rd_idx) + CW'(1);
    assign w_wr_adv = (w_wr_inc >= r_depth) ? '0 : AW'(w_wr_inc);
    assign w_rd_adv = (w_rd_inc >= r_depth) ? '0 : AW'(w_rd_inc);

    always_comb begin
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_count    = r_count;
        n_peak     = r_peak;
        n_next_seq = r_next_seq;
        n_closed   = r_closed;
        n_drop_ctr = r_drop_ctr;
        n_pub_ctr  = r_pub_ctr;
        n_cons_ctr = r_cons_ctr;
        n_byte_ctr = r_byte_ctr;
        n_status   = drq_pkg::ST_OK;
        n_seq      = '0;
        n_dropped  = 1'b0;
        n_rd_ok    = 1'b0;
        w_pub      = 1'b0;
        w_cons     = 1'b0;
        case (i_op)
            drq_pkg::OP_PUBLISH: begin
                if (r_closed) begin
                    n_status = drq_pkg::ST_CLOSED;
                end else begin
                    w_pub = 1'b1;
                    // full: oldest entry goes, count stays the same
                    if (r_count >= r_depth) begin
                        n_rd_idx   = w_rd_adv;
                        n_drop_ctr = r_drop_ctr + 64'd1;
                        n_dropped  = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    n_seq      = r_next_seq;
                    n_next_seq = r_next_seq + 64'd1;
                    n_wr_idx   = w_wr_adv;
                    n_pub_ctr  = r_pub_ctr + 64'd1;
                    n_byte_ctr = r_byte_ctr + 64'(i_bytes);
                    if (n_count > r_peak) begin
                        n_peak = n_count;
                    end
                end
            end
            drq_pkg::OP_CONSUME: begin
                if (r_count == '0) begin
                    n_status = r_closed ? drq_pkg::ST_CLOSED : drq_pkg::ST_EMPTY;
                end else begin
                    w_cons     = 1'b1;
                    n_rd_ok    = 1'b1;
                    n_rd_idx   = w_rd_adv;
                    n_count    = r_count - CW'(1);
                    n_cons_ctr = r_cons_ctr + 64'd1;
                end
            end
            drq_pkg::OP_CLOSE: begin
                n_closed = 1'b1;
            end
            default: begin
                // undefined op: nothing changes
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= CW'(drq_pkg::eff_depth(drq_pkg::RING_DEPTH_RST, MAX_DEPTH));
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_count    <= '0;
            r_peak     <= '0;
            r_next_seq <= '0;
            r_closed   <= 1'b0;
            r_drop_ctr <= '0;
            r_pub_ctr  <= '0;
            r_cons_ctr <= '0;
            r_byte_ctr <= '0;
            r_status   <= drq_pkg::ST_OK;
            r_seq      <= '0;
            r_dropped  <= 1'b0;
            r_rd_ok    <= 1'b0;
        end else if (i_cfg_we) begin
            // new depth empties the ring; statistics stay
            r_depth  <= CW'(drq_pkg::eff_depth(i_cfg_wdata, MAX_DEPTH));
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_count    <= n_count;
            r_peak     <= n_peak;
            r_next_seq <= n_next_seq;
            r_closed   <= n_closed;
            r_drop_ctr <= n_drop_ctr;
            r_pub_ctr  <= n_pub_ctr;
            r_cons_ctr <= n_cons_ctr;
            r_byte_ctr <= n_byte_ctr;
            r_status   <= n_status;
            r_seq      <= n_seq;
            r_dropped  <= n_dropped;
            r_rd_ok    <= n_rd_ok;
        end
    end

    assign o_we            = i_accept && w_pub;
    assign o_waddr         = r_wr_idx;
    assign o_wentry.slot   = i_slot;
    assign o_wentry.handle = i_handle;
    assign o_wentry.bytes  = i_bytes;
    assign o_wentry.seq    = r_next_seq;
    assign o_re            = i_accept && w_cons;
    assign o_raddr         = r_rd_idx;

    assign o_status     = r_status;
    assign o_seq        = r_seq;
    assign o_dropped    = r_dropped;
    assign o_rd_ok      = r_rd_ok;
    assign o_count      = r_count;
    assign o_peak       = r_peak;
    assign o_drop_total = r_drop_ctr;
    assign o_pub_total  = r_pub_ctr;
    assign o_cons_total = r_cons_ctr;
    assign o_byte_total = r_byte_ctr;

endmodule

[sv/drop_oldest_ring_queue.sv]
// Drop-oldest ring queue: a bounded FIFO of (slot, handle, byte count)
// entries with running statistics. Depends on drq_pkg, drq_ctrl, drq_store.
//
// Each input transaction (tuser = op: publish, consume or close) produces
// exactly one result transaction in the next cycle; a new transaction is
// taken every cycle as long as the result register is empty or being
// drained, so sustained throughput is one transaction per clock. The cycle
// is set by the pointer/count update plus one 64-bit counter add, and by a
// single-port-write, single-port-read entry memory (MAX_DEPTH x 192 bits)
// whose read data register doubles as the result register for consumed
// entries. A publish into a full ring silently retires the oldest entry and
// flags dropped_now. Publish after close returns status closed and stores
// nothing; consume on an empty ring returns closed or empty. Writing the
// depth register (clamped to 2..MAX_DEPTH) empties the ring but keeps the
// statistics, sequence number and closed flag; do it only while no result
// is pending. The entry memory needs no clearing pass after reset: the
// queued count guarantees only written entries are ever read.
module drop_oldest_ring_queue #(
    parameter int unsigned MAX_DEPTH = drq_pkg::MAX_DEPTH_DEF,
    localparam int unsigned AW = $clog2(MAX_DEPTH),
    localparam int unsigned CW = $clog2(MAX_DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: ring_depth
    input  logic                       i_cfg_we,
    input  logic [drq_pkg::CFG_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [127:0]               i_s_axis_tdata,  // in_slot[63:0], in_handle[95:64],
                                                        // in_bytes[127:96]
    input  logic [1:0]                 i_s_axis_tuser,  // op[1:0]
    // result stream
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [471:0]               o_m_axis_tdata,  // out_slot[63:0], out_handle[95:64],
                                                        // out_bytes[127:96], out_seq[191:128],
                                                        // dropped_now[192], queued[203:193],
                                                        // peak_queued[214:204],
                                                        // dropped_total[278:215],
                                                        // published_total[342:279],
                                                        // consumed_total[406:343],
                                                        // bytes_total[470:407], zero[471]
    output logic [1:0]                 o_m_axis_tuser   // status[1:0]
);

    logic            r_out_valid;
    logic            w_accept;

    logic            w_we, w_re;
    logic [AW-1:0]   w_waddr, w_raddr;
    drq_pkg::t_entry w_wentry, w_rentry;

    logic [1:0]      w_status;
    logic [63:0]     w_seq;
    logic            w_dropped, w_rd_ok;
    logic [CW-1:0]   w_count, w_peak;
    logic [63:0]     w_drop_total, w_pub_total, w_cons_total, w_byte_total;

    logic [63:0]     w_out_slot, w_out_seq;
    logic [31:0]     w_out_handle, w_out_bytes;
    logic [drq_pkg::CNT_OUT_W-1:0] w_queued, w_high;

    // result register frees up when taken, so input never waits on a
    // result that is leaving this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    drq_ctrl #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (w_accept),
        .i_op         (i_s_axis_tuser),
        .i_slot       (i_s_axis_tdata[63:0]),
        .i_handle     (i_s_axis_tdata[95:64]),
        .i_bytes      (i_s_axis_tdata[127:96]),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wentry     (w_wentry),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .o_status     (w_status),
        .o_seq        (w_seq),
        .o_dropped    (w_dropped),
        .o_rd_ok      (w_rd_ok),
        .o_count      (w_count),
        .o_peak       (w_peak),
        .o_drop_total (w_drop_total),
        .o_pub_total  (w_pub_total),
        .o_cons_total (w_cons_total),
        .o_byte_total (w_byte_total)
    );

    drq_store #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wentry (w_wentry),
        .i_re     (w_re),
        .i_raddr  (w_raddr),
        .o_rentry (w_rentry)
    );

    // entry fields only show for a successful consume; out_seq also carries a publish's seq
    assign w_out_slot   = w_rd_ok ? w_rentry.slot   : '0;
    assign w_out_handle = w_rd_ok ? w_rentry.handle : '0;
    assign w_out_bytes  = w_rd_ok ? w_rentry.bytes  : '0;
    assign w_out_seq    = w_rd_ok ? w_rentry.seq    : w_seq;
    assign w_queued     = drq_pkg::CNT_OUT_W'(w_count);
    assign w_high       = drq_pkg::CNT_OUT_W'(w_peak);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = w_status;
    assign o_m_axis_tdata  = {1'b0, w_byte_total, w_cons_total, w_pub_total, w_drop_total,
                              w_high, w_queued, w_dropped, w_out_seq, w_out_bytes,
                              w_out_handle, w_out_slot};

`ifndef SYNTH
    // every accepted transaction leaves a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");

    // an empty report only comes with an empty ring
    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && w_status == drq_pkg::ST_EMPTY) |-> (w_count == '0))
        else $error("empty status with entries queued");

    // a drop only happens on a successful publish into a non-empty ring
    a_drop_is_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && w_dropped) |-> (w_status == drq_pkg::ST_OK && !w_rd_ok
                                        && w_count != '0))
        else $error("drop flagged outside a full publish");

    // peak count never trails the queued count
    a_peak_covers_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (w_peak >= w_count))
        else $error("peak count below queued count");
`endif

endmodule

[sim/tb.sv]
// Self-checking testbench for drop_oldest_ring_queue: stream driver, result monitor and
// a cycle-free behavioral ring model that predicts every result transaction.
// Depends on drq_pkg and the drop_oldest_ring_queue RTL.
module tb;

    // tuser value outside the defined op set; the block must treat it as a no-op
    localparam logic [1:0] OP_UNDEF = 2'd3;
    localparam int unsigned RING_MAX = drq_pkg::MAX_DEPTH_DEF;
    localparam int unsigned HOLD_CYCLES = 150;

    // One input transaction: op plus the entry carried by a publish
    typedef struct {
        logic [1:0]  op;
        logic [63:0] slot;
        logic [31:0] handle;
        logic [31:0] nbytes;
    } t_queue_req;

    // One result transaction, unpacked field by field
    typedef struct {
        logic [1:0]  status;
        logic [63:0] slot;
        logic [31:0] handle;
        logic [31:0] nbytes;
        logic [63:0] seq;
        logic        dropped;
        logic [10:0] queued;
        logic [10:0] peak_queued;
        logic [63:0] drops;
        logic [63:0] pubs;
        logic [63:0] cons;
        logic [63:0] byte_sum;
    } t_queue_resp;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [drq_pkg::CFG_W-1:0]  i_cfg_wdata = '0;
    logic                       i_s_axis_tvalid = 1'b0;
    logic                       o_s_axis_tready;
    logic [127:0]               i_s_axis_tdata = '0;   // in_slot, in_handle, in_bytes
    logic [1:0]                 i_s_axis_tuser = '0;   // op
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b0;
    logic [471:0]               o_m_axis_tdata;        // see the port list of the block
    logic [1:0]                 o_m_axis_tuser;        // status

    drop_oldest_ring_queue DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Ring model state (own copy of the block's state and depth register)
    // ------------------------------------------------------------------
    drq_pkg::t_entry ring_mem [RING_MAX];
    int unsigned  wr_ptr, rd_ptr, fill, peak;
    logic [63:0]  seq_next, drop_cnt, pub_cnt, cons_cnt, byte_sum;
    logic         is_closed;
    logic [10:0]  depth_setting;

    t_queue_req   op_backlog[$];    // transactions waiting for the driver
    t_queue_resp  due_results[$];   // predicted results, oldest first
    t_queue_req   cur_req;          // transaction currently on the input bus

    int ops_sent, results_seen, errors, n_cfg;
    int n_drops, n_empty, n_refused;
    int src_gap_pct, snk_gap_pct;   // idle probabilities per decision, percent
    int gap_left, stall_left, hold_left;
    int hold_req, hold_seen;

    // Depth write: effective at once, and the ring is emptied. Statistics,
    // sequence number and closed flag survive.
    function automatic void load_depth(logic [10:0] v);
        depth_setting = v;
        wr_ptr = 0;
        rd_ptr = 0;
        fill = 0;
    endfunction

    // Apply one accepted transaction to the ring model and return the result
    // the block has to produce for it.
    function automatic t_queue_resp ring_step(t_queue_req r);
        t_queue_resp res;
        int unsigned d;
        d = 32'(depth_setting);
        if (d < 2) begin
            d = 2;
        end else if (d > RING_MAX) begin
            d = RING_MAX;
        end
        res = '{default: '0};
        res.status = drq_pkg::ST_OK;
        // pointers left beyond a smaller depth restart at the bottom
        if (wr_ptr >= d) wr_ptr = 0;
        if (rd_ptr >= d) rd_ptr = 0;
        case (r.op)
            drq_pkg::OP_PUBLISH: begin
                if (is_closed) begin
                    res.status = drq_pkg::ST_CLOSED;
                end else begin
                    if (fill >= d) begin
                        // full ring: retire the oldest entry first
                        rd_ptr = (rd_ptr + 1 >= d) ? 0 : rd_ptr + 1;
                        fill--;
                        drop_cnt++;
                        res.dropped = 1'b1;
                    end
                    ring_mem[wr_ptr] = '{seq: seq_next, bytes: r.nbytes,
                                         handle: r.handle, slot: r.slot};
                    res.seq = seq_next;
                    seq_next++;
                    wr_ptr = (wr_ptr + 1 >= d) ? 0 : wr_ptr + 1;
                    fill++;
                    pub_cnt++;
                    byte_sum += {32'd0, r.nbytes};
                    if (fill > peak) peak = fill;
                end
            end
            drq_pkg::OP_CONSUME: begin
                if (fill == 0) begin
                    res.status = is_closed ? drq_pkg::ST_CLOSED : drq_pkg::ST_EMPTY;
                end else begin
                    res.slot   = ring_mem[rd_ptr].slot;
                    res.handle = ring_mem[rd_ptr].handle;
                    res.nbytes = ring_mem[rd_ptr].bytes;
                    res.seq    = ring_mem[rd_ptr].seq;
                    rd_ptr = (rd_ptr + 1 >= d) ? 0 : rd_ptr + 1;
                    fill--;
                    cons_cnt++;
                end
            end
            drq_pkg::OP_CLOSE: begin
                is_closed = 1'b1;
            end
            default: begin
                // undefined op: no state change, statistics only
            end
        endcase
        res.queued      = 11'(fill);
        res.peak_queued = 11'(peak);
        res.drops       = drop_cnt;
        res.pubs        = pub_cnt;
        res.cons        = cons_cnt;
        res.byte_sum    = byte_sum;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers backlog transactions, with random idle bursts.
    // tvalid is written once per edge; it stays up while a transaction
    // waits for tready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                due_results.push_back(ring_step(cur_req));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
                    // start an idle burst; gap_left counts the idle decisions still to come
                    gap_left = $urandom_range(8, 0);
                    i_s_axis_tvalid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    cur_req = op_backlog.pop_front();
                    i_s_axis_tdata  <= {cur_req.nbytes, cur_req.handle, cur_req.slot};
                    i_s_axis_tuser  <= cur_req.op;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side tready: random stall bursts, plus a long hold-off on
    // request so the block backs up and deasserts its input tready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (snk_gap_pct != 0 && $urandom_range(99) < snk_gap_pct) begin
                stall_left = $urandom_range(8, 0);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: every accepted result transaction against the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_queue_resp got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            got.status      = o_m_axis_tuser;
            got.slot        = o_m_axis_tdata[63:0];
            got.handle      = o_m_axis_tdata[95:64];
            got.nbytes      = o_m_axis_tdata[127:96];
            got.seq         = o_m_axis_tdata[191:128];
            got.dropped     = o_m_axis_tdata[192];
            got.queued      = o_m_axis_tdata[203:193];
            got.peak_queued = o_m_axis_tdata[214:204];
            got.drops       = o_m_axis_tdata[278:215];
            got.pubs        = o_m_axis_tdata[342:279];
            got.cons        = o_m_axis_tdata[406:343];
            got.byte_sum    = o_m_axis_tdata[470:407];
            if (due_results.size() == 0) begin
                $display("%0t: result transaction with nothing outstanding, status %0h",
                         $time, got.status);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (want.dropped) n_drops++;
                if (want.status == drq_pkg::ST_EMPTY) n_empty++;
                if (want.status == drq_pkg::ST_CLOSED) n_refused++;
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("out_slot", want.slot, got.slot);
                check_field("out_handle", 64'(want.handle), 64'(got.handle));
                check_field("out_bytes", 64'(want.nbytes), 64'(got.nbytes));
                check_field("out_seq", want.seq, got.seq);
                check_field("dropped_now", 64'(want.dropped), 64'(got.dropped));
                check_field("queued", 64'(want.queued), 64'(got.queued));
                check_field("peak_queued", 64'(want.peak_queued), 64'(got.peak_queued));
                check_field("dropped_total", want.drops, got.drops);
                check_field("published_total", want.pubs, got.pubs);
                check_field("consumed_total", want.cons, got.cons);
                check_field("bytes_total", want.byte_sum, got.byte_sum);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] pick64();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(input logic [1:0] op, input logic [63:0] slot,
                           input logic [31:0] handle, input logic [31:0] nbytes);
        op_backlog.push_back('{op: op, slot: slot, handle: handle, nbytes: nbytes});
        ops_sent++;
    endtask

    task automatic push_rand(input logic [1:0] op);
        push_op(op, pick64(), pick32(), pick32());
    endtask

    // Block is idle once every sent transaction has come back as a result.
    // The result is registered in the cycle after input, so a short pause is enough.
    task automatic wait_drained();
        while (results_seen != ops_sent) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_depth(input logic [10:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        load_depth(v);
        n_cfg++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random phase: mostly publishes and consumes with random content,
    // a thin sprinkle of undefined ops.
    task automatic run_phase(input logic [10:0] depth, input int n, input int pub_pct);
        int k;
        write_depth(depth);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < pub_pct) begin
                push_rand(drq_pkg::OP_PUBLISH);
            end else if (k == 99) begin
                push_rand(OP_UNDEF);
            end else begin
                push_rand(drq_pkg::OP_CONSUME);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // depth written, items, publish percent, sender and receiver idle percent
        int ph_depth [6];
        int ph_items [6];
        int ph_pub   [6];
        int ph_src   [6];
        int ph_snk   [6];

        ph_depth = '{3, 7, 2047, 1024, 2, 61};
        ph_items = '{60, 70, 30, 1120, 50, 120};
        ph_pub   = '{55, 50, 60, 97, 60, 60};
        ph_src   = '{25, 40, 0, 10, 30, 0};
        ph_snk   = '{25, 0, 40, 10, 30, 0};

        ops_sent = 0;
        results_seen = 0;
        errors = 0;
        n_cfg = 0;
        n_drops = 0;
        n_empty = 0;
        n_refused = 0;
        hold_req = 0;
        src_gap_pct = 20;
        snk_gap_pct = 20;

        // model reset state
        wr_ptr = 0;
        rd_ptr = 0;
        fill = 0;
        peak = 0;
        seq_next = '0;
        drop_cnt = '0;
        pub_cnt = '0;
        cons_cnt = '0;
        byte_sum = '0;
        is_closed = 1'b0;
        depth_setting = drq_pkg::RING_DEPTH_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset depth, empty consume, undefined op, field extremes
        push_rand(drq_pkg::OP_CONSUME);
        push_rand(OP_UNDEF);
        push_op(drq_pkg::OP_PUBLISH, 64'd0, 32'd0, 32'd0);
        push_op(drq_pkg::OP_PUBLISH, '1, '1, '1);
        push_op(drq_pkg::OP_PUBLISH, {32{2'b10}}, {16{2'b01}}, {16{2'b10}});
        repeat (3) push_rand(drq_pkg::OP_CONSUME);
        push_rand(drq_pkg::OP_CONSUME);

        // Depth below the minimum acts as 2: third publish drops the oldest
        write_depth(11'd1);
        repeat (3) push_rand(drq_pkg::OP_PUBLISH);
        repeat (3) push_rand(drq_pkg::OP_CONSUME);
        push_rand(drq_pkg::OP_PUBLISH);
        // a depth write empties the ring; the queued entry is gone
        write_depth(11'd0);
        push_rand(drq_pkg::OP_CONSUME);

        // Random phases over several depths, including the upper clamp and the minimum
        for (int p = 0; p < 6; p++) begin
            src_gap_pct = ph_src[p];
            snk_gap_pct = ph_snk[p];
            run_phase(11'(ph_depth[p]), ph_items[p], ph_pub[p]);
            // long receiver hold-off while the sender keeps offering
            if (p == 0) hold_req++;
        end

        // Closing sequence: refused publish, drain, closed-empty consume
        write_depth(11'd5);
        repeat (2) push_rand(drq_pkg::OP_PUBLISH);
        push_rand(drq_pkg::OP_CLOSE);
        push_rand(drq_pkg::OP_PUBLISH);
        repeat (3) push_rand(drq_pkg::OP_CONSUME);
        push_rand(drq_pkg::OP_CLOSE);
        push_rand(OP_UNDEF);

        wait_drained();
        repeat (5) @(posedge i_clk);

        $display("Checked %0d result transactions over %0d depth writes (2 to 1024 effective).",
                 results_seen, n_cfg);
        $display("Saw %0d oldest-entry drops, %0d empty consumes, %0d closed refusals.",
                 n_drops, n_empty, n_refused);
        if (errors == 0) begin
            $display("** drop_oldest_ring_queue: PASSED **");
        end else begin
            $display("** drop_oldest_ring_queue: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #6000000;
        $display("Timeout: %0d of %0d results received", results_seen, ops_sent);
        $display("** drop_oldest_ring_queue: FAILED **");
        $finish;
    end

endmodule
